// ----- rtl/dlb_pkg.sv -----
package dlb_pkg;

  // Fixed field widths of the item ports
  localparam int unsigned FIELD_W = 31;
  localparam int unsigned EXP_W   = 32;
  // Baby-step index as kept in the store
  localparam int unsigned J_W     = 16;

  typedef enum logic [1:0] {
    OP_FIND,
    OP_INSERT,
    OP_CLEAR
  } store_op_e;

  typedef struct packed {
    logic      valid;
    store_op_e op;
  } store_req_t;

  typedef struct packed {
    logic           idle;
    logic           done;
    logic           hit;
    logic [J_W-1:0] j;
  } store_rsp_t;

  typedef enum logic [2:0] {
    SS_INIT,
    SS_IDLE,
    SS_PROBE,
    SS_CHECK,
    SS_CLEAR
  } store_state_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_T,
    ST_SQRT,
    ST_EUC_GO,
    ST_EUC_WAIT,
    ST_EUC_UPD,
    ST_EUC_NORM,
    ST_CLEAR,
    ST_B_GO,
    ST_B_MT,
    ST_B_INS,
    ST_B_MI,
    ST_B_MA,
    ST_G_GO,
    ST_G_FIND,
    ST_G_MW,
    ST_DONE
  } dlb_state_e;

endpackage

// ----- rtl/dlb_mmul.sv -----
module dlb_mmul #(
  parameter int unsigned VW = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [VW-1:0] x_i,
  input  logic [VW-1:0] y_i,
  input  logic [VW-1:0] md_i,
  output logic          done_o,
  output logic [VW-1:0] res_o,
  output logic [VW-1:0] quo_o
);
  import dlb_pkg::*;

  localparam int unsigned CW = (VW > 1) ? $clog2(VW) : 1;

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] r_q, q_q, x_q, y_q, md_q;

  logic [VW+1:0] sum, t1, t2, md_ext;
  logic          qbit;

  // One bit of y per cycle: r = (2r + bit*x) mod md, x no larger than md
  always_comb begin
    md_ext = {2'b00, md_q};
    sum    = {1'b0, r_q, 1'b0} + (y_q[VW-1] ? {2'b00, x_q} : '0);
    qbit   = (sum >= md_ext);
    t1     = qbit ? (sum - md_ext) : sum;
    t2     = (t1 >= md_ext) ? (t1 - md_ext) : t1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      r_q    <= '0;
      q_q    <= '0;
      x_q    <= '0;
      y_q    <= '0;
      md_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(VW - 1);
        r_q    <= '0;
        q_q    <= '0;
        x_q    <= x_i;
        y_q    <= y_i;
        md_q   <= md_i;
      end else if (busy_q) begin
        r_q <= t2[VW-1:0];
        q_q <= {q_q[VW-2:0], qbit};
        y_q <= {y_q[VW-2:0], 1'b0};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;
  assign quo_o  = q_q;

endmodule

// ----- rtl/dlb_store.sv -----
module dlb_store #(
  parameter int unsigned TABLE_ENTRIES = 65536,
  parameter int unsigned VW            = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dlb_pkg::store_req_t   req_i,
  input  logic [VW-1:0]         value_i,
  input  logic [dlb_pkg::J_W-1:0] j_i,
  output dlb_pkg::store_rsp_t   rsp_o
);
  import dlb_pkg::*;

  localparam int unsigned LIST_AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned SLOT_W  = LIST_AW + 1;
  localparam int unsigned SLOT_N  = 2 ** SLOT_W;
  localparam int unsigned FILL_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ENT_W   = 1 + VW + J_W;
  localparam int unsigned CHUNKS  = (VW + SLOT_W - 1) / SLOT_W;

  function automatic logic [SLOT_W-1:0] hash_f(logic [VW-1:0] v);
    logic [SLOT_W-1:0]    h;
    logic [VW+SLOT_W-1:0] ext;
    h   = '0;
    ext = {{SLOT_W{1'b0}}, v};
    for (int k = 0; k < CHUNKS; k++) h = h ^ ext[k*SLOT_W +: SLOT_W];
    return h;
  endfunction

  logic [ENT_W-1:0]  slot_mem_q [SLOT_N];
  logic [SLOT_W-1:0] list_mem_q [TABLE_ENTRIES];
  logic [ENT_W-1:0]  slot_rd_q;
  logic [SLOT_W-1:0] list_rd_q;

  store_state_e      st_q, st_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [FILL_W-1:0] clr_q, clr_d, fill_q, fill_d;
  logic              pend_q, pend_d;
  store_op_e         op_q, op_d;
  logic [VW-1:0]     val_q, val_d;
  logic [J_W-1:0]    j_q, j_d, hitj_q, hitj_d;
  logic              done_q, done_d, hit_q, hit_d;

  logic               slot_we, slot_re, list_we, list_re;
  logic [SLOT_W-1:0]  slot_waddr, slot_raddr;
  logic [ENT_W-1:0]   slot_wdata;
  logic [LIST_AW-1:0] list_waddr, list_raddr;
  logic [SLOT_W-1:0]  list_wdata;

  logic           ent_v;
  logic [VW-1:0]  ent_val;
  logic [J_W-1:0] ent_j;

  assign ent_v   = slot_rd_q[ENT_W-1];
  assign ent_val = slot_rd_q[VW+J_W-1:J_W];
  assign ent_j   = slot_rd_q[J_W-1:0];

  always_comb begin
    st_d       = st_q;
    idx_d      = idx_q;
    clr_d      = clr_q;
    fill_d     = fill_q;
    pend_d     = pend_q;
    op_d       = op_q;
    val_d      = val_q;
    j_d        = j_q;
    hitj_d     = hitj_q;
    hit_d      = hit_q;
    done_d     = 1'b0;
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    list_we    = 1'b0;
    list_re    = 1'b0;
    slot_waddr = idx_q;
    slot_raddr = idx_q;
    slot_wdata = '0;
    list_waddr = fill_q[LIST_AW-1:0];
    list_raddr = clr_q[LIST_AW-1:0];
    list_wdata = idx_q;
    case (st_q)
      SS_INIT: begin
        // sweep every slot empty after reset
        slot_we = 1'b1;
        idx_d   = idx_q + SLOT_W'(1);
        if (idx_q == '1) st_d = SS_IDLE;
      end
      SS_IDLE: begin
        if (req_i.valid) begin
          case (req_i.op)
            OP_CLEAR: begin
              clr_d  = '0;
              pend_d = 1'b0;
              st_d   = SS_CLEAR;
            end
            OP_FIND, OP_INSERT: begin
              op_d  = req_i.op;
              val_d = value_i;
              j_d   = j_i;
              idx_d = hash_f(value_i);
              st_d  = SS_PROBE;
            end
            default: st_d = SS_IDLE;
          endcase
        end
      end
      SS_PROBE: begin
        slot_re = 1'b1;
        st_d    = SS_CHECK;
      end
      SS_CHECK: begin
        if (ent_v && (ent_val == val_q)) begin
          hit_d  = 1'b1;
          hitj_d = ent_j;
          done_d = 1'b1;
          st_d   = SS_IDLE;
        end else if (!ent_v) begin
          hit_d  = 1'b0;
          done_d = 1'b1;
          st_d   = SS_IDLE;
          if ((op_q == OP_INSERT) && (fill_q < FILL_W'(TABLE_ENTRIES))) begin
            slot_we    = 1'b1;
            slot_wdata = {1'b1, val_q, j_q};
            list_we    = 1'b1;
            fill_d     = fill_q + FILL_W'(1);
          end
        end else begin
          // linear probe onwards
          idx_d = idx_q + SLOT_W'(1);
          st_d  = SS_PROBE;
        end
      end
      SS_CLEAR: begin
        // read the slot list one ahead, empty the slot read last cycle
        list_re    = (clr_q < fill_q);
        slot_we    = pend_q;
        slot_waddr = list_rd_q;
        pend_d     = list_re;
        if (list_re) clr_d = clr_q + FILL_W'(1);
        if (!list_re && !pend_q) begin
          fill_d = '0;
          done_d = 1'b1;
          st_d   = SS_IDLE;
        end
      end
      default: st_d = SS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem_q[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rd_q <= slot_mem_q[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (list_we) list_mem_q[list_waddr] <= list_wdata;
    if (list_re) list_rd_q <= list_mem_q[list_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SS_INIT;
      idx_q  <= '0;
      clr_q  <= '0;
      fill_q <= '0;
      pend_q <= 1'b0;
      op_q   <= OP_FIND;
      val_q  <= '0;
      j_q    <= '0;
      hitj_q <= '0;
      hit_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      clr_q  <= clr_d;
      fill_q <= fill_d;
      pend_q <= pend_d;
      op_q   <= op_d;
      val_q  <= val_d;
      j_q    <= j_d;
      hitj_q <= hitj_d;
      hit_q  <= hit_d;
      done_q <= done_d;
    end
  end

  assign rsp_o.idle = (st_q == SS_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.hit  = hit_q;
  assign rsp_o.j    = hitj_q;

endmodule

// ----- rtl/discrete_log_bsgs.sv -----
// Baby-step giant-step discrete logarithm: finds x with base^x = target mod
// modulus and returns one result item (found, exponent) per input item.
// All modular products, reductions and Euclid quotients go through one
// bit-serial multiply/remainder unit, and the baby steps live in a
// linear-probing hash memory.
// With m = floor(sqrt(modulus))+1 an item takes m baby steps and up to m
// giant steps, after the inverse and after the entries of the previous
// item are emptied from the hash memory; trivial cases (zero modulus, or
// base a multiple of the modulus with a nonzero target) skip the search.
// After reset all 2^(clog2(TABLE_ENTRIES)+1) hash slots (131072 by default)
// are swept empty before the first item is taken.
module discrete_log_bsgs #(
  parameter int unsigned TABLE_ENTRIES = 65536,
  parameter int unsigned MODULUS_BITS  = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dlb_pkg::FIELD_W-1:0] base_i,
  input  logic [dlb_pkg::FIELD_W-1:0] target_i,
  input  logic [dlb_pkg::FIELD_W-1:0] modulus_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [dlb_pkg::EXP_W-1:0]   exponent_o
);
  import dlb_pkg::*;

  localparam int unsigned VW     = MODULUS_BITS;
  localparam int unsigned ROOT_W = (MODULUS_BITS + 1) / 2;
  localparam int unsigned SQ_W   = 2 * ROOT_W;
  localparam int unsigned M_W    = ROOT_W + 1;
  localparam int unsigned RK_W   = $clog2(ROOT_W);
  localparam int unsigned S_W    = VW + 2;

  dlb_state_e st_q, st_d;
  logic [VW-1:0]         a_q, a_d, t_q, t_d, c_q, c_d;
  logic [VW-1:0]         r0_q, r0_d, r1_q, r1_d, quo_q, quo_d;
  logic signed [S_W-1:0] s0_q, s0_d, s1_q, s1_d;
  logic [VW-1:0]         inv_q, inv_d, ipw_q, ipw_d, pw_q, pw_d, w_q, w_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [RK_W-1:0]       rk_q, rk_d;
  logic [M_W-1:0]        m_q, m_d, i_q, i_d;
  logic                  res_found_q, res_found_d;
  logic [EXP_W-1:0]      res_exp_q, res_exp_d;
  logic                  out_valid_q, out_valid_d, out_found_q, out_found_d;
  logic [EXP_W-1:0]      out_exp_q, out_exp_d;

  logic          mm_start, mm_done;
  logic [VW-1:0] mm_x, mm_y, mm_md, mm_res, mm_quo;

  store_req_t     sreq;
  store_rsp_t     srsp;
  logic [VW-1:0]  svalue;
  logic [J_W-1:0] sj;

  logic                  in_acc;
  logic [ROOT_W-1:0]     cand, root_nx;
  logic [SQ_W-1:0]       sq;
  logic signed [VW+S_W:0] prod;
  logic signed [S_W-1:0] c_ext, ts;
  logic [2*M_W-1:0]      im;
  logic [M_W-1:0]        i_inc;
  logic [VW-1:0]         a_in, t_in, c_in;

  dlb_mmul #(.VW(VW)) u_mmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .x_i     (mm_x),
    .y_i     (mm_y),
    .md_i    (mm_md),
    .done_o  (mm_done),
    .res_o   (mm_res),
    .quo_o   (mm_quo)
  );

  dlb_store #(.TABLE_ENTRIES(TABLE_ENTRIES), .VW(VW)) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sreq),
    .value_i (svalue),
    .j_i     (sj),
    .rsp_o   (srsp)
  );

  assign in_stall_o = !((st_q == ST_IDLE) && srsp.idle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign a_in       = base_i[VW-1:0];
  assign t_in       = target_i[VW-1:0];
  assign c_in       = modulus_i[VW-1:0];

  assign cand    = root_q | (ROOT_W'(1) << rk_q);
  assign sq      = cand * cand;
  assign root_nx = (sq <= SQ_W'(c_q)) ? cand : root_q;
  assign prod    = $signed({1'b0, quo_q}) * s1_q;
  assign ts      = s0_q - $signed(prod[S_W-1:0]);
  assign c_ext   = $signed({2'b00, c_q});
  assign im      = i_q * m_q;
  assign i_inc   = i_q + M_W'(1);

  always_comb begin
    st_d        = st_q;
    a_d         = a_q;
    t_d         = t_q;
    c_d         = c_q;
    r0_d        = r0_q;
    r1_d        = r1_q;
    quo_d       = quo_q;
    s0_d        = s0_q;
    s1_d        = s1_q;
    inv_d       = inv_q;
    ipw_d       = ipw_q;
    pw_d        = pw_q;
    w_d         = w_q;
    root_d      = root_q;
    rk_d        = rk_q;
    m_d         = m_q;
    i_d         = i_q;
    res_found_d = res_found_q;
    res_exp_d   = res_exp_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_found_d = out_found_q;
    out_exp_d   = out_exp_q;
    mm_start    = 1'b0;
    mm_x        = VW'(1);
    mm_y        = '0;
    mm_md       = c_q;
    sreq.valid  = 1'b0;
    sreq.op     = OP_FIND;
    svalue      = w_q;
    sj          = J_W'(i_q);
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          a_d = a_in;
          t_d = t_in;
          c_d = c_in;
          if (c_in == '0) begin
            res_found_d = 1'b0;
            res_exp_d   = '0;
            st_d        = ST_DONE;
          end else begin
            mm_start = 1'b1;
            mm_y     = a_in;
            mm_md    = c_in;
            st_d     = ST_RED_A;
          end
        end
      end
      ST_RED_A: begin
        if (mm_done) begin
          a_d      = mm_res;
          mm_start = 1'b1;
          mm_y     = t_q;
          st_d     = ST_RED_T;
        end
      end
      ST_RED_T: begin
        if (mm_done) begin
          t_d = mm_res;
          if ((a_q == '0) && (mm_res != '0)) begin
            res_found_d = (mm_res == VW'(1));
            res_exp_d   = '0;
            st_d        = ST_DONE;
          end else begin
            root_d = '0;
            rk_d   = RK_W'(ROOT_W - 1);
            st_d   = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        // one root bit per cycle, most significant first
        root_d = root_nx;
        rk_d   = rk_q - RK_W'(1);
        if (rk_q == '0) begin
          m_d  = M_W'(root_nx) + M_W'(1);
          r0_d = a_q;
          r1_d = c_q;
          s0_d = S_W'(1);
          s1_d = '0;
          st_d = ST_EUC_GO;
        end
      end
      ST_EUC_GO: begin
        mm_start = 1'b1;
        mm_y     = r0_q;
        mm_md    = r1_q;
        st_d     = ST_EUC_WAIT;
      end
      ST_EUC_WAIT: begin
        mm_md = r1_q;
        if (mm_done) begin
          quo_d = mm_quo;
          r0_d  = r1_q;
          r1_d  = mm_res;
          st_d  = ST_EUC_UPD;
        end
      end
      ST_EUC_UPD: begin
        s0_d = s1_q;
        s1_d = ts;
        st_d = (r1_q == '0) ? ST_EUC_NORM : ST_EUC_GO;
      end
      ST_EUC_NORM: begin
        if (s0_q < 0) begin
          inv_d = VW'(s0_q + c_ext);
        end else if (s0_q >= c_ext) begin
          inv_d = VW'(s0_q - c_ext);
        end else begin
          inv_d = VW'(s0_q);
        end
        sreq.valid = 1'b1;
        sreq.op    = OP_CLEAR;
        st_d       = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (srsp.done) begin
          i_d   = '0;
          ipw_d = VW'(1);
          pw_d  = VW'(1);
          st_d  = ST_B_GO;
        end
      end
      ST_B_GO: begin
        mm_start = 1'b1;
        mm_x     = ipw_q;
        mm_y     = t_q;
        st_d     = ST_B_MT;
      end
      ST_B_MT: begin
        if (mm_done) begin
          sreq.valid = 1'b1;
          sreq.op    = OP_INSERT;
          svalue     = mm_res;
          st_d       = ST_B_INS;
        end
      end
      ST_B_INS: begin
        if (srsp.done) begin
          mm_start = 1'b1;
          mm_x     = ipw_q;
          mm_y     = inv_q;
          st_d     = ST_B_MI;
        end
      end
      ST_B_MI: begin
        if (mm_done) begin
          ipw_d    = mm_res;
          mm_start = 1'b1;
          mm_x     = pw_q;
          mm_y     = a_q;
          st_d     = ST_B_MA;
        end
      end
      ST_B_MA: begin
        if (mm_done) begin
          pw_d = mm_res;
          if (i_inc == m_q) begin
            i_d  = '0;
            w_d  = (c_q == VW'(1)) ? '0 : VW'(1);
            st_d = ST_G_GO;
          end else begin
            i_d  = i_inc;
            st_d = ST_B_GO;
          end
        end
      end
      ST_G_GO: begin
        sreq.valid = 1'b1;
        sreq.op    = OP_FIND;
        st_d       = ST_G_FIND;
      end
      ST_G_FIND: begin
        if (srsp.done) begin
          if (srsp.hit) begin
            res_found_d = 1'b1;
            res_exp_d   = EXP_W'(im) + EXP_W'(srsp.j);
            st_d        = ST_DONE;
          end else if (i_inc == m_q) begin
            res_found_d = 1'b0;
            res_exp_d   = '0;
            st_d        = ST_DONE;
          end else begin
            i_d      = i_inc;
            mm_start = 1'b1;
            mm_x     = w_q;
            mm_y     = pw_q;
            st_d     = ST_G_MW;
          end
        end
      end
      ST_G_MW: begin
        if (mm_done) begin
          w_d  = mm_res;
          st_d = ST_G_GO;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_exp_d   = res_exp_q;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      a_q         <= '0;
      t_q         <= '0;
      c_q         <= '0;
      r0_q        <= '0;
      r1_q        <= '0;
      quo_q       <= '0;
      s0_q        <= '0;
      s1_q        <= '0;
      inv_q       <= '0;
      ipw_q       <= '0;
      pw_q        <= '0;
      w_q         <= '0;
      root_q      <= '0;
      rk_q        <= '0;
      m_q         <= '0;
      i_q         <= '0;
      res_found_q <= 1'b0;
      res_exp_q   <= '0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      out_exp_q   <= '0;
    end else begin
      st_q        <= st_d;
      a_q         <= a_d;
      t_q         <= t_d;
      c_q         <= c_d;
      r0_q        <= r0_d;
      r1_q        <= r1_d;
      quo_q       <= quo_d;
      s0_q        <= s0_d;
      s1_q        <= s1_d;
      inv_q       <= inv_d;
      ipw_q       <= ipw_d;
      pw_q        <= pw_d;
      w_q         <= w_d;
      root_q      <= root_d;
      rk_q        <= rk_d;
      m_q         <= m_d;
      i_q         <= i_d;
      res_found_q <= res_found_d;
      res_exp_q   <= res_exp_d;
      out_valid_q <= out_valid_d;
      out_found_q <= out_found_d;
      out_exp_q   <= out_exp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign exponent_o  = out_exp_q;

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (exponent_o == '0))
    else $error("exponent not zero on a failed search");

  a_store_req_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sreq.valid |-> srsp.idle)
    else $error("store request while store busy");

  a_mul_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mm_done && (st_q == ST_B_MT || st_q == ST_B_MI || st_q == ST_B_MA ||
                 st_q == ST_G_MW)) |-> (mm_res < c_q))
    else $error("modular product not reduced");

endmodule

// ----- tb/discrete_log_bsgs_test.sv -----
module discrete_log_bsgs_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dlb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20000000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_ITEMS = 81;
  localparam longint unsigned FIELD_MAX = 64'h7FFF_FFFF;

  typedef struct {
    logic               found;
    logic [EXP_W-1:0]   exponent;
  } dlog_result_t;

  typedef struct {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] target;
    logic [FIELD_W-1:0] modulus;
    bit                 typed;
    logic               found;
    logic [EXP_W-1:0]   exponent;
  } dlog_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [FIELD_W-1:0] base_i = '0;
  logic [FIELD_W-1:0] target_i = '0;
  logic [FIELD_W-1:0] modulus_i = 31'd1;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               found_o;
  logic [EXP_W-1:0]   exponent_o;

  dlog_result_t pending_logs[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  cycle_count = 0;
  int unsigned  error_count = 0;

  discrete_log_bsgs DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .base_i     (base_i),
    .target_i   (target_i),
    .modulus_i  (modulus_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .found_o    (found_o),
    .exponent_o (exponent_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint unsigned mod_pow(longint unsigned b, longint unsigned e,
                                              longint unsigned c);
    longint unsigned acc;
    acc = 64'd1 % c;
    b = b % c;
    while (e != 0) begin
      if (e[0]) acc = acc * b % c;
      b = b * b % c;
      e = e >> 1;
    end
    return acc;
  endfunction

  // Baby steps target*inv^j keyed by value, first j kept; giant steps base^(i*m).
  function automatic dlog_result_t solve_dlog(logic [FIELD_W-1:0] b_in,
                                              logic [FIELD_W-1:0] t_in,
                                              logic [FIELD_W-1:0] c_in);
    dlog_result_t     res;
    longint unsigned  a, t, c, m, inv, ipw, pw, w, i, now, n, r, bit_v;
    longint           r0, r1, s0, s1, q, tr, ts;
    int unsigned      first_j [longint unsigned];
    a = 64'(b_in);
    t = 64'(t_in);
    c = 64'(c_in);
    res.found = 1'b0;
    res.exponent = '0;
    if (c == 0) return res;
    a = a % c;
    t = t % c;
    if (a == 0 && t != 0) begin
      res.found = (t == 1);
      return res;
    end
    n = c;
    r = 0;
    bit_v = 64'd1 << 40;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n = n - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    m = r + 1;
    r0 = a;
    r1 = c;
    s0 = 1;
    s1 = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      tr = r0 - q * r1;
      ts = s0 - q * s1;
      r0 = r1;
      r1 = tr;
      s0 = s1;
      s1 = ts;
    end
    inv = longint'(((s0 % longint'(c)) + longint'(c)) % longint'(c));
    ipw = 1;
    pw = 1;
    for (i = 0; i < m; i++) begin
      now = ipw * t % c;
      if (!first_j.exists(now)) first_j[now] = 32'(i[15:0]);
      ipw = ipw * inv % c;
      pw = pw * a % c;
    end
    w = 64'd1 % c;
    for (i = 0; i < m; i++) begin
      if (first_j.exists(w)) begin
        res.found = 1'b1;
        res.exponent = EXP_W'(i * m + first_j[w]);
        return res;
      end
      w = w * pw % c;
    end
    return res;
  endfunction

  task automatic send_item(logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] t,
                           logic [FIELD_W-1:0] c, bit typed, dlog_result_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    base_i = b;
    target_i = t;
    modulus_i = c;
    do @(posedge clk_i); while (in_stall_o);
    pending_logs.insert(pending_logs.size(), typed ? typed_res : solve_dlog(b, t, c));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("discrete_log_bsgs regression: fail");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_logs.size() == 0) begin
        $error("result item with nothing expected: found %0b exponent %0d",
               found_o, exponent_o);
        error_count++;
      end else begin
        if (found_o !== pending_logs[0].found) begin
          $error("found: expected %0b actual %0b", pending_logs[0].found, found_o);
          error_count++;
        end
        if (exponent_o !== pending_logs[0].exponent) begin
          $error("exponent: expected %0d actual %0d", pending_logs[0].exponent, exponent_o);
          error_count++;
        end
        void'(pending_logs.pop_front());
      end
    end
  end

  initial begin
    dlog_row_t       rows[$];
    dlog_result_t    typed_res;
    longint unsigned c, b, t, k, p;
    int unsigned     sel;
    bit              is_prime;

    rows = '{
      '{31'd0, 31'd1, 31'h7FFF_FFFF, 1'b1, 1'b1, 32'd0},
      '{31'd0, 31'd5, 31'h7FFF_FFFF, 1'b1, 1'b0, 32'd0},
      '{31'h7FFF_FFFF, 31'h7FFF_FFFE, 31'h7FFF_FFFF, 1'b1, 1'b0, 32'd0},
      '{31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF, 1'b1, 1'b1, 32'd0},
      '{31'd0, 31'd0, 31'd1, 1'b1, 1'b1, 32'd0},
      '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1, 1'b1, 1'b1, 32'd0},
      '{31'd0, 31'd0, 31'd101, 1'b1, 1'b1, 32'd11},
      '{31'd3, 31'd13, 31'd17, 1'b0, 1'b0, 32'd0},
      '{31'd2, 31'd1, 31'd1999, 1'b0, 1'b0, 32'd0},
      '{31'd6, 31'd6, 31'd15, 1'b0, 1'b0, 32'd0},
      '{31'd6, 31'd9, 31'd15, 1'b0, 1'b0, 32'd0},
      '{31'd1, 31'd2, 31'd1999, 1'b0, 1'b0, 32'd0},
      '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1997, 1'b0, 1'b0, 32'd0},
      '{31'd5, 31'd0, 31'd23, 1'b0, 1'b0, 32'd0},
      '{31'd1998, 31'd1, 31'd1999, 1'b0, 1'b0, 32'd0},
      '{31'd4, 31'd1000, 31'd2, 1'b0, 1'b0, 32'd0},
      '{31'd7, 31'd3, 31'd2003, 1'b0, 1'b0, 32'd0}
    };

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 77 : 0;
      recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 8 : 0;
      if (ph == 0) begin
        foreach (rows[r]) begin
          typed_res.found = rows[r].found;
          typed_res.exponent = rows[r].exponent;
          send_item(rows[r].base, rows[r].target, rows[r].modulus, rows[r].typed,
                    typed_res);
        end
      end
      for (int n = 0; n < RANDOM_ITEMS / 3 + 1; n++) begin
        sel = $urandom_range(99);
        if (sel < 15) begin
          // wide modulus, base a multiple of it: fast path, exercises the high bits
          c = 64'($urandom_range(2, 32'h7FFF_FFFF));
          b = ($urandom_range(1) != 0) ? c : 64'd0;
          t = 64'({1'b0, $urandom}) & FIELD_MAX;
          send_item(FIELD_W'(b), FIELD_W'(t), FIELD_W'(c), 1'b0, typed_res);
        end else begin
          do begin
            c = 64'($urandom_range(2, 2000));
            is_prime = 1'b1;
            for (p = 2; p * p <= c; p++) if (c % p == 0) is_prime = 1'b0;
          end while (sel < 80 && !is_prime);
          b = 64'({1'b0, $urandom}) & FIELD_MAX;
          if (sel < 80) begin
            // reachable target, lifted by a random multiple of the modulus
            k = 64'($urandom_range(0, 32'(2 * c)));
            t = mod_pow(b, k, c);
            t = t + c * 64'($urandom_range(0, 32'((FIELD_MAX - t) / c)));
          end else begin
            t = 64'({1'b0, $urandom}) & FIELD_MAX;
          end
          send_item(FIELD_W'(b), FIELD_W'(t), FIELD_W'(c), 1'b0, typed_res);
        end
      end
    end

    while (pending_logs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("discrete_log_bsgs regression: pass");
    end else begin
      $display("discrete_log_bsgs regression: fail");
    end
    $finish;
  end

endmodule
